[rtl/cfar_2d_window_detector_top_macros.svh]
// Assertion helpers shared by the detector modules.
// Every helper samples on i_clk and is off while i_rst_n is low.
`ifndef CFAR_2D_WINDOW_DETECTOR_TOP_MACROS_SVH
`define CFAR_2D_WINDOW_DETECTOR_TOP_MACROS_SVH
// The condition must never hold.
`define CFAR2D_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
// When ante holds, cons holds in the same cycle.
`define CFAR2D_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// When ante holds, cons holds in the next cycle.
`define CFAR2D_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/cfar2d_pkg.sv]
`default_nettype none
package cfar2d_pkg;

    localparam int IDX_BITS   = 12;
    localparam int TCFAR_BITS = 15;
    localparam int TCFAR_DIV  = 25600;
    localparam int ROW_BITS   = 12;
    localparam int ROW_LIMIT  = 4096;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW = 3'd0,
        CFG_GUARD  = 3'd1,
        CFG_TCFAR  = 3'd2,
        CFG_LIMIT  = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } t_cfg_idx;

    // Window geometry after clamping, shared by front and back.
    typedef struct packed {
        logic [3:0] n;
        logic [3:0] base;
        logic [3:0] ctr;
        logic [2:0] ghalf;
        logic [7:0] area;
    } t_geom;

    // Queue status toward both sides.
    typedef struct packed {
        logic empty;
        logic full;
        logic afull;
    } t_q_stat;

endpackage
`default_nettype wire

[rtl/cfar2d_fifo.sv]
`default_nettype none
module cfar2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output cfar2d_pkg::t_q_stat     o_stat
);
`include "cfar_2d_window_detector_top_macros.svh"

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_stat.afull = (r_count >= CNT_BITS'(DEPTH - 1));

    `CFAR2D_NEVER(a_no_overflow, i_push && (r_count == CNT_BITS'(DEPTH)), "queue overflow")
    `CFAR2D_NEVER(a_no_underflow, i_pop && (r_count == '0), "queue underflow")
    `CFAR2D_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count slip")

endmodule
`default_nettype wire

[rtl/cfar2d_front.sv]
`default_nettype none
module cfar2d_front #(
    parameter int MAX_WINDOW = 9,
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 16,
    parameter int CELL_W     = VALUE_BITS + 24,
    parameter int COL_CNT_BITS = 11,
    parameter int QW         = MAX_WINDOW * CELL_W + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [VALUE_BITS-1:0]   i_corr_value,
    input  wire logic [cfar2d_pkg::IDX_BITS-1:0] i_src_x,
    input  wire logic [cfar2d_pkg::IDX_BITS-1:0] i_src_y,
    input  wire cfar2d_pkg::t_geom       i_geom,
    input  wire logic [COL_CNT_BITS-1:0] i_width,
    input  wire logic [cfar2d_pkg::ROW_BITS:0] i_height,
    input  wire cfar2d_pkg::t_q_stat     i_q_stat,
    output logic                         o_push,
    output logic [QW-1:0]                o_data
);

    localparam int LINES     = MAX_WINDOW - 1;
    localparam int SLOT_BITS = $clog2(LINES);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int RB        = cfar2d_pkg::ROW_BITS;

    logic [COL_BITS-1:0]  r_col;
    logic [RB-1:0]        r_row;
    logic [SLOT_BITS-1:0] r_slot;
    logic                 r_s1_valid;
    logic                 r_s1_elig;
    logic [SLOT_BITS-1:0] r_s1_slot;
    logic [CELL_W-1:0]    r_s1_cell;
    logic [CELL_W-1:0]    r_rd [LINES];

    logic                 accept;
    logic [COL_BITS-1:0]  c;
    logic [RB-1:0]        r;
    logic [SLOT_BITS-1:0] s;
    logic [CELL_W-1:0]    in_cell;
    logic [COL_CNT_BITS-1:0] c_next;
    logic [RB:0]          r_next;
    logic [3:0]           n_m1;

    assign o_stall = i_q_stat.full || (r_s1_valid && i_q_stat.afull);
    assign accept  = i_valid && !o_stall;

    // A counter at or past the current map size restarts at zero.
    assign c    = ({1'b0, r_col} >= (COL_BITS+1)'(i_width)) ? '0 : r_col;
    assign r    = ({1'b0, r_row} >= i_height) ? '0 : r_row;
    assign s    = ({1'b0, r_row} >= i_height) ? '0 : r_slot;
    assign in_cell = {i_corr_value, i_src_x, i_src_y};
    assign c_next = COL_CNT_BITS'(c) + 1'b1;
    assign r_next = {1'b0, r} + 1'b1;
    assign n_m1   = i_geom.n - 4'd1;

    for (genvar k = 0; k < LINES; k++) begin : g_line
        logic [CELL_W-1:0] r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (accept && (s == SLOT_BITS'(k))) begin
                r_mem[c] <= in_cell;
            end
        end

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd[k] <= r_mem[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_slot     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (c_next >= i_width) begin
                    r_col <= '0;
                    if (r_next >= i_height) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_next[RB-1:0];
                        r_slot <= (s == SLOT_BITS'(LINES - 1)) ? '0 : s + 1'b1;
                    end
                end else begin
                    r_col  <= c_next[COL_BITS-1:0];
                    r_row  <= r;
                    r_slot <= s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_slot <= s;
            r_s1_cell <= in_cell;
            r_s1_elig <= (r >= RB'(n_m1)) && (c >= COL_BITS'(n_m1));
        end
    end

    // Window row i takes the line of row r-(LINES-i), held in slot (s+i) mod LINES.
    always_comb begin
        logic [SLOT_BITS:0] idx;
        o_data = '0;
        for (int i = 0; i < LINES; i++) begin
            idx = {1'b0, r_s1_slot} + (SLOT_BITS+1)'(i);
            if (idx >= (SLOT_BITS+1)'(LINES)) begin
                idx = idx - (SLOT_BITS+1)'(LINES);
            end
            o_data[i*CELL_W +: CELL_W] = r_rd[idx[SLOT_BITS-1:0]];
        end
        o_data[LINES*CELL_W +: CELL_W] = r_s1_cell;
        o_data[QW-1] = r_s1_elig;
    end

    assign o_push = r_s1_valid;

endmodule
`default_nettype wire

[rtl/cfar2d_back.sv]
`default_nettype none
module cfar2d_back #(
    parameter int MAX_WINDOW = 9,
    parameter int VALUE_BITS = 16,
    parameter int CELL_W     = VALUE_BITS + 24,
    parameter int QW         = MAX_WINDOW * CELL_W + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire cfar2d_pkg::t_q_stat     i_q_stat,
    input  wire logic [QW-1:0]           i_data,
    output logic                         o_pop,
    input  wire cfar2d_pkg::t_geom       i_geom,
    input  wire logic [cfar2d_pkg::TCFAR_BITS-1:0] i_tcfar,
    input  wire logic signed [VALUE_BITS-1:0] i_limit,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [cfar2d_pkg::IDX_BITS-1:0] o_det_x,
    output logic [cfar2d_pkg::IDX_BITS-1:0] o_det_y,
    output logic signed [VALUE_BITS-1:0] o_det_value
);
`include "cfar_2d_window_detector_top_macros.svh"

    localparam int IB        = cfar2d_pkg::IDX_BITS;
    localparam int WIN_BITS  = $clog2(MAX_WINDOW);
    localparam int CNT_BITS  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int PROD_BITS = cfar2d_pkg::TCFAR_BITS + 9;

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_COUNT, ST_DECIDE} t_state;

    t_state                   r_state;
    logic [CELL_W-1:0]        r_win [MAX_WINDOW][MAX_WINDOW];
    logic                     r_elig;
    logic signed [VALUE_BITS-1:0] r_cut;
    logic [IB-1:0]            r_cx;
    logic [IB-1:0]            r_cy;
    logic [PROD_BITS-1:0]     r_prod;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [WIN_BITS-1:0]      r_row;
    logic                     r_ovalid;
    logic [IB-1:0]            r_det_x;
    logic [IB-1:0]            r_det_y;
    logic signed [VALUE_BITS-1:0] r_det_value;

    logic [CELL_W-1:0]        ctr_cell;
    logic signed [VALUE_BITS-1:0] ctr_val;
    logic [3:0]               row_cnt;
    logic [PROD_BITS-1:0]     bound;
    logic                     hit;
    logic                     out_free;
    logic                     det_load;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign ctr_cell = r_win[i_geom.ctr[WIN_BITS-1:0]][i_geom.ctr[WIN_BITS-1:0]];
    assign ctr_val  = $signed(ctr_cell[CELL_W-1 -: VALUE_BITS]);
    assign out_free = !r_ovalid || !i_stall;
    assign det_load = (r_state == ST_DECIDE) && hit && out_free;

    // Count test: floor(prod / div) <= cnt exactly when prod < (cnt + 1) * div.
    assign bound = PROD_BITS'(r_cnt + 1'b1) * PROD_BITS'(cfar2d_pkg::TCFAR_DIV);
    assign hit   = (r_prod < bound);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                for (int j = 0; j < MAX_WINDOW - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][MAX_WINDOW-1] <= i_data[i*CELL_W +: CELL_W];
            end
        end
    end

    // One window row per cycle: cells inside the window, outside the guard, above the cut.
    always_comb begin
        logic [3:0] di;
        logic [3:0] dj;
        logic [3:0] ri;
        logic signed [VALUE_BITS-1:0] v;
        row_cnt = '0;
        ri = 4'(r_row);
        di = (ri > i_geom.ctr) ? ri - i_geom.ctr : i_geom.ctr - ri;
        for (int j = 0; j < MAX_WINDOW; j++) begin
            dj = (4'(j) > i_geom.ctr) ? 4'(j) - i_geom.ctr : i_geom.ctr - 4'(j);
            v  = $signed(r_win[r_row][j][CELL_W-1 -: VALUE_BITS]);
            if ((ri >= i_geom.base) && (4'(j) >= i_geom.base)
                && !((di <= {1'b0, i_geom.ghalf}) && (dj <= {1'b0, i_geom.ghalf}))
                && (v > r_cut)) begin
                row_cnt = row_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (det_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_elig  <= i_data[QW-1];
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_cut  <= ctr_val;
                    r_cx   <= ctr_cell[2*IB-1:IB];
                    r_cy   <= ctr_cell[IB-1:0];
                    r_prod <= PROD_BITS'(i_tcfar) * PROD_BITS'(i_geom.area);
                    r_cnt  <= '0;
                    r_row  <= '0;
                    if (r_elig && (ctr_val < i_limit)) begin
                        r_state <= ST_COUNT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_COUNT: begin
                    r_cnt <= r_cnt + CNT_BITS'(row_cnt);
                    if (r_row == WIN_BITS'(MAX_WINDOW - 1)) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (!hit) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_det_x     <= r_cx;
                        r_det_y     <= r_cy;
                        r_det_value <= r_cut;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_det_x     = r_det_x;
    assign o_det_y     = r_det_y;
    assign o_det_value = r_det_value;

    `CFAR2D_SAME(a_pop_idle, o_pop, r_state == ST_IDLE, "pop outside idle")
    `CFAR2D_NEXT(a_count_end, (r_state == ST_COUNT) && (r_row == WIN_BITS'(MAX_WINDOW - 1)),
        r_state == ST_DECIDE, "count pass did not end")
    `CFAR2D_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_det_value), "detection dropped")

endmodule
`default_nettype wire

[rtl/cfar_2d_window_detector_top.sv]
// Two-dimensional order-statistic CFAR detector over a correlation map.
// Input channel: one map cell per transfer (i_valid / o_stall), in raster
// order, carrying its signed value and its source x and y indices.
// Output channel: one detection per transfer (o_valid / i_stall) with the
// indices and value of a window centre that passed the test; a cell yields
// zero or one detection, always in input order.
// A fetched column passes the front's stage register, the queue and the back
// end's idle and check states. A cell that cannot be a detection ends there;
// a candidate also passes the count state, where the back end scans the window
// one row per cycle, which sets the sustained rate, then the decide state.
// A four-entry queue lets the front keep taking cells while the back scans.
// Reset (synchronous, active low) clears the position counters, the queue
// and the output valid flag and loads the register defaults. The line stores
// are not cleared; windows only read lines written earlier in the same map.
// When the receiver stalls, the detection holds in the output register; the
// back end may scan the next candidate and wait in its decide state; the queue
// then fills and raises o_stall. Configuration writes belong to idle periods only.
`default_nettype none
module cfar_2d_window_detector_top #(
    parameter int MAX_WINDOW = 9,
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [cfar2d_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [((VALUE_BITS > 15) ? VALUE_BITS : 15)-1:0] i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [VALUE_BITS-1:0] i_corr_value,
    input  wire logic [cfar2d_pkg::IDX_BITS-1:0] i_src_x,
    input  wire logic [cfar2d_pkg::IDX_BITS-1:0] i_src_y,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [cfar2d_pkg::IDX_BITS-1:0] o_det_x,
    output logic [cfar2d_pkg::IDX_BITS-1:0] o_det_y,
    output logic signed [VALUE_BITS-1:0] o_det_value
);

    localparam int CELL_W       = VALUE_BITS + 2 * cfar2d_pkg::IDX_BITS;
    localparam int QW           = MAX_WINDOW * CELL_W + 1;
    localparam int COL_CNT_BITS = $clog2(MAX_WIDTH + 1);
    localparam int RB           = cfar2d_pkg::ROW_BITS;
    localparam logic [3:0] CAP  = 4'((MAX_WINDOW - 1) | 1);

    // Configuration registers.
    logic [3:0]               r_window;
    logic [2:0]               r_guard;
    logic [cfar2d_pkg::TCFAR_BITS-1:0] r_tcfar;
    logic signed [VALUE_BITS-1:0] r_limit;
    logic [10:0]              r_width;
    logic [12:0]              r_height;

    cfar2d_pkg::t_geom        geom;
    logic [COL_CNT_BITS-1:0]  width_c;
    logic [RB:0]              height_c;
    cfar2d_pkg::t_q_stat      q_stat;
    logic                     q_push;
    logic                     q_pop;
    logic [QW-1:0]            q_wdata;
    logic [QW-1:0]            q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 4'd9;
            r_guard  <= 3'd3;
            r_tcfar  <= '0;
            r_limit  <= VALUE_BITS'(26214);
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfar2d_pkg::CFG_WINDOW: r_window <= i_cfg_data[3:0];
                cfar2d_pkg::CFG_GUARD:  r_guard  <= i_cfg_data[2:0];
                cfar2d_pkg::CFG_TCFAR:  r_tcfar  <= i_cfg_data[cfar2d_pkg::TCFAR_BITS-1:0];
                cfar2d_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[VALUE_BITS-1:0];
                cfar2d_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                cfar2d_pkg::CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // The window side is made odd and held between 3 and the largest odd size
    // that fits; the guard is made odd and never larger than the window.
    always_comb begin
        logic [3:0] n;
        logic [3:0] g;
        logic [3:0] half;
        n = r_window | 4'd1;
        if (n < 4'd3) begin
            n = 4'd3;
        end
        if (n > CAP) begin
            n = CAP;
        end
        g = {1'b0, r_guard} | 4'd1;
        if (g > n) begin
            g = n;
        end
        half       = {1'b0, n[3:1]};
        geom.n     = n;
        geom.base  = 4'(MAX_WINDOW) - n;
        geom.ctr   = 4'(MAX_WINDOW - 1) - half;
        geom.ghalf = g[3:1];
        geom.area  = 8'(n) * 8'(n) - 8'(g) * 8'(g);
    end

    // Map size clamped to 1..MAX_WIDTH columns and 1..4096 rows.
    always_comb begin
        if (r_width == '0) begin
            width_c = COL_CNT_BITS'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            width_c = COL_CNT_BITS'(MAX_WIDTH);
        end else begin
            width_c = COL_CNT_BITS'(r_width);
        end
        if (r_height == '0) begin
            height_c = (RB+1)'(1);
        end else if (32'(r_height) > cfar2d_pkg::ROW_LIMIT) begin
            height_c = (RB+1)'(cfar2d_pkg::ROW_LIMIT);
        end else begin
            height_c = r_height;
        end
    end

    // Front: position tracking, line stores and the column fetch.
    cfar2d_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_WIDTH    (MAX_WIDTH),
        .VALUE_BITS   (VALUE_BITS),
        .CELL_W       (CELL_W),
        .COL_CNT_BITS (COL_CNT_BITS),
        .QW           (QW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_corr_value (i_corr_value),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_geom       (geom),
        .i_width      (width_c),
        .i_height     (height_c),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_data       (q_wdata)
    );

    // Queue of fetched columns between the two halves.
    cfar2d_fifo #(
        .WIDTH   (QW),
        .DEPTH   (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    // Back: window shift, cut test, row-by-row count and the output register.
    cfar2d_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .VALUE_BITS  (VALUE_BITS),
        .CELL_W      (CELL_W),
        .QW          (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_data      (q_rdata),
        .o_pop       (q_pop),
        .i_geom      (geom),
        .i_tcfar     (r_tcfar),
        .i_limit     (r_limit),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_det_x     (o_det_x),
        .o_det_y     (o_det_y),
        .o_det_value (o_det_value)
    );

endmodule
`default_nettype wire
